// ===== sv/vss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vss_pkg
// Shared types, widths and register indexes of the speech segmenter.
// ----------------------------------------------------------------------------
package vss_pkg;

  localparam int INDEX_BITS     = 16;
  localparam int PROB_BITS      = 16;
  localparam int FIELD_BITS     = 16;
  localparam int CFG_INDEX_BITS = 8;

  // Compare width for probabilities and thresholds, and working width for
  // index arithmetic against the 16-bit frame count registers.
  localparam int CMP_BITS = (PROB_BITS < FIELD_BITS) ? PROB_BITS : FIELD_BITS;
  localparam int CNT_BITS = (INDEX_BITS > FIELD_BITS) ? INDEX_BITS : FIELD_BITS;

  localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ON_THRESHOLD       = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_OFF_THRESHOLD      = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_SILENCE_FRAMES = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_SPEECH_FRAMES  = CFG_INDEX_BITS'(3);

  localparam logic [FIELD_BITS-1:0] ON_THRESHOLD_RST       = FIELD_BITS'(32768);
  localparam logic [FIELD_BITS-1:0] OFF_THRESHOLD_RST      = FIELD_BITS'(22938);
  localparam logic [FIELD_BITS-1:0] MIN_SILENCE_FRAMES_RST = FIELD_BITS'(8);
  localparam logic [FIELD_BITS-1:0] MIN_SPEECH_FRAMES_RST  = FIELD_BITS'(4);

  typedef struct packed {
    logic [FIELD_BITS-1:0] frame_prob;
    logic                  first_of_call;
    logic                  last_of_call;
  } frame_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] seg_start;
    logic [FIELD_BITS-1:0] seg_end;
    logic                  ran_to_end;
  } segment_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] on_threshold;
    logic [FIELD_BITS-1:0] off_threshold;
    logic [FIELD_BITS-1:0] min_silence_frames;
    logic [FIELD_BITS-1:0] min_speech_frames;
  } cfg_t;

  typedef struct packed {
    logic                  active;
    logic [INDEX_BITS-1:0] start_index;
    logic                  silence_pending;
    logic [INDEX_BITS-1:0] silence_start;
    logic [INDEX_BITS-1:0] frame_index;
  } seg_state_t;

endpackage

// ===== sv/vss_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vss_cfg
// Configuration register file: thresholds and minimum frame counts.
// ----------------------------------------------------------------------------
module vss_cfg
  import vss_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [FIELD_BITS-1:0]     cfg_data,
  output cfg_t                      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_threshold       <= ON_THRESHOLD_RST;
      cfg.off_threshold      <= OFF_THRESHOLD_RST;
      cfg.min_silence_frames <= MIN_SILENCE_FRAMES_RST;
      cfg.min_speech_frames  <= MIN_SPEECH_FRAMES_RST;
    end else if (cfg_valid) begin
      // Indexes beyond the register list are accepted and dropped.
      case (cfg_index)
        REG_ON_THRESHOLD:       cfg.on_threshold       <= cfg_data;
        REG_OFF_THRESHOLD:      cfg.off_threshold      <= cfg_data;
        REG_MIN_SILENCE_FRAMES: cfg.min_silence_frames <= cfg_data;
        REG_MIN_SPEECH_FRAMES:  cfg.min_speech_frames  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/vss_decide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vss_decide
// Per-frame hysteresis decision: next segment state and optional report.
// ----------------------------------------------------------------------------
module vss_decide
  import vss_pkg::*;
(
  input  seg_state_t state,
  input  cfg_t       cfg,
  input  frame_t     frame,
  output seg_state_t state_next,
  output logic       res_valid,
  output segment_t   res
);

  logic [CMP_BITS-1:0]   p;
  logic [CMP_BITS-1:0]   on_t;
  logic [CMP_BITS-1:0]   off_t;
  logic                  ge_on;
  logic                  lt_off;
  logic [INDEX_BITS-1:0] idx;
  logic [INDEX_BITS-1:0] st;
  logic                  pend;
  logic [INDEX_BITS-1:0] ss;
  logic                  act;
  logic [INDEX_BITS-1:0] sil_len;
  logic [INDEX_BITS-1:0] seg_len;
  logic                  close;
  logic                  report;
  logic                  silence_path;

  assign p      = frame.frame_prob[CMP_BITS-1:0];
  assign on_t   = cfg.on_threshold[CMP_BITS-1:0];
  assign off_t  = cfg.off_threshold[CMP_BITS-1:0];
  assign ge_on  = (p >= on_t);
  assign lt_off = (p < off_t);

  always_comb begin
    // A first frame restarts the call's indexes before the decision.
    idx  = frame.first_of_call ? '0 : state.frame_index;
    st   = frame.first_of_call ? '0 : state.start_index;
    pend = frame.first_of_call ? 1'b0 : state.silence_pending;
    ss   = frame.first_of_call ? '0 : state.silence_start;
    act  = state.active;

    if (ge_on) begin
      pend = 1'b0;
    end

    silence_path = !(ge_on && !act) && lt_off && act;

    if (ge_on && !act) begin
      act = 1'b1;
      st  = idx;
    end else if (silence_path && !pend) begin
      pend = 1'b1;
      ss   = idx;
    end

    sil_len = idx - ss;
    seg_len = (ss > st) ? (ss - st) : '0;
    close   = silence_path &&
              (CNT_BITS'(sil_len) >= CNT_BITS'(cfg.min_silence_frames));
    report  = close && (CNT_BITS'(seg_len) > CNT_BITS'(cfg.min_speech_frames));

    res_valid = 1'b0;
    res       = '0;
    if (report) begin
      res_valid      = 1'b1;
      res.seg_start  = FIELD_BITS'(CNT_BITS'(st));
      res.seg_end    = FIELD_BITS'(CNT_BITS'(ss));
      res.ran_to_end = 1'b0;
    end

    if (close) begin
      st   = '0;
      ss   = '0;
      pend = 1'b0;
      act  = 1'b0;
    end

    if (frame.last_of_call && act && !report) begin
      res_valid      = 1'b1;
      res.seg_start  = FIELD_BITS'(CNT_BITS'(st));
      res.seg_end    = FIELD_BITS'(CNT_BITS'(idx));
      res.ran_to_end = 1'b1;
    end

    state_next.active          = act;
    state_next.start_index     = st;
    state_next.silence_pending = pend;
    state_next.silence_start   = ss;
    state_next.frame_index     = (idx < IDX_MAX) ? (idx + 1'b1) : idx;
  end

endmodule

// ===== sv/vad_speech_segmenter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_speech_segmenter
// Hysteresis speech segmenter: turns per-frame speech probabilities into
// reported segment boundaries.
// ----------------------------------------------------------------------------
// A transferred frame is held in the frame register and decided there; its
// segment, if any, is loaded into the output register when the frame moves
// on, and is offered on the output from then on.
// Throughput: one frame per cycle; the input register stalls only when a
// frame produces a segment while the output register holds one not taken.
// Reset clears the segment state and loads the registers with their defaults.
module vad_speech_segmenter
  import vss_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  frame_t                    in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output segment_t                  out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [FIELD_BITS-1:0]     cfg_data
);

  cfg_t       cfg;
  frame_t     frame;
  logic       frame_valid;
  seg_state_t state;
  seg_state_t state_next;
  logic       res_valid;
  segment_t   res;
  logic       advance;

  vss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vss_decide u_decide (
    .state      (state),
    .cfg        (cfg),
    .frame      (frame),
    .state_next (state_next),
    .res_valid  (res_valid),
    .res        (res)
  );

  // The held frame moves on unless it has a segment to hand over and the
  // output register is full and not being drained.
  assign advance  = frame_valid && (!res_valid || !out_valid || out_ready);
  assign in_ready = !frame_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (in_ready) begin
      frame_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frame <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_data <= res;
    end
  end

endmodule

// ===== sv/vss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vss_checker
// Port-level checks on the speech segmenter, bound to the top level.
// ----------------------------------------------------------------------------
module vss_checker
  import vss_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     out_valid,
  input logic     out_ready,
  input segment_t out_data
);

  // A stalled segment must not change or vanish before its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("segment changed while stalled");

  // Nothing is offered in the cycle after a reset edge.
  a_out_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("segment offered straight after reset");

  // A segment closed by silence has been checked for a positive length.
  a_silence_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.ran_to_end |-> out_data.seg_end > out_data.seg_start)
    else $error("silence-closed segment without positive length");

  // An end-of-call segment never ends before it starts.
  a_end_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.ran_to_end |-> out_data.seg_end >= out_data.seg_start)
    else $error("end-of-call segment ends before its start");

endmodule

bind vad_speech_segmenter vss_checker u_vss_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the speech segmenter. Frames are sent over the
// input channel while a frame-by-frame tracker of the segmenter state predicts
// each reported segment, and every output transfer is checked against the
// oldest prediction. It covers directed threshold and length edges and
// random calls under several register settings.
// ----------------------------------------------------------------------------
module testbench;
  import vss_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 8;
  localparam int DRAIN_CYCLES   = 6;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_FRAMES   = 95;

  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = REG_MIN_SPEECH_FRAMES + 1'b1;
  localparam logic [FIELD_BITS-1:0]     PROB_MAX   = '1;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  frame_t                    in_data   = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  segment_t                  out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [FIELD_BITS-1:0]     cfg_data  = '0;

  // Tracker of the segmenter: registers and segment state as the block holds them.
  cfg_t       model_cfg;
  seg_state_t track;

  segment_t expected_segments[$];
  bit       idle_on     = 1'b1;
  int       stall_left  = 0;
  int       err_count   = 0;
  int       cycle_count = 0;

  vad_speech_segmenter u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  function automatic frame_t mk_frame(input logic [FIELD_BITS-1:0] prob,
                                      input logic is_first, input logic is_last);
    frame_t f;
    f.frame_prob    = prob;
    f.first_of_call = is_first;
    f.last_of_call  = is_last;
    return f;
  endfunction

  // Advances the tracker by one frame; returns 1 when the frame reports a segment.
  function automatic bit predict_segment(input frame_t f, output segment_t seg);
    logic [CMP_BITS-1:0]   p;
    logic [CMP_BITS-1:0]   on_t;
    logic [CMP_BITS-1:0]   off_t;
    logic [INDEX_BITS-1:0] idx;
    logic [CNT_BITS-1:0]   quiet_len;
    logic [CNT_BITS-1:0]   speech_len;
    bit                    found;
    p     = f.frame_prob[CMP_BITS-1:0];
    on_t  = model_cfg.on_threshold[CMP_BITS-1:0];
    off_t = model_cfg.off_threshold[CMP_BITS-1:0];
    found = 1'b0;
    seg   = '0;
    if (f.first_of_call) begin
      track.frame_index     = '0;
      track.start_index     = '0;
      track.silence_pending = 1'b0;
      track.silence_start   = '0;
    end
    idx = track.frame_index;
    if (p >= on_t) track.silence_pending = 1'b0;
    if (p >= on_t && !track.active) begin
      track.active      = 1'b1;
      track.start_index = idx;
    end else if (p < off_t && track.active) begin
      if (!track.silence_pending) begin
        track.silence_pending = 1'b1;
        track.silence_start   = idx;
      end
      quiet_len = CNT_BITS'(idx - track.silence_start);
      if (quiet_len >= CNT_BITS'(model_cfg.min_silence_frames)) begin
        // A silence that began at or before the segment start gives zero length.
        speech_len = (track.silence_start > track.start_index) ?
                     CNT_BITS'(track.silence_start - track.start_index) : '0;
        if (speech_len > CNT_BITS'(model_cfg.min_speech_frames)) begin
          seg.seg_start  = FIELD_BITS'(track.start_index);
          seg.seg_end    = FIELD_BITS'(track.silence_start);
          seg.ran_to_end = 1'b0;
          found          = 1'b1;
        end
        track.start_index     = '0;
        track.silence_start   = '0;
        track.silence_pending = 1'b0;
        track.active          = 1'b0;
      end
    end
    if (f.last_of_call && track.active && !found) begin
      seg.seg_start  = FIELD_BITS'(track.start_index);
      seg.seg_end    = FIELD_BITS'(idx);
      seg.ran_to_end = 1'b1;
      found          = 1'b1;
    end
    if (track.frame_index != IDX_MAX) track.frame_index = track.frame_index + 1'b1;
    return found;
  endfunction

  // Valid is left high after the transfer; the next call or settle decides.
  task automatic send_frame(input frame_t f);
    segment_t seg;
    int       gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (predict_segment(f, seg)) expected_segments = {expected_segments, seg};
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [FIELD_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      REG_ON_THRESHOLD:       model_cfg.on_threshold       = value;
      REG_OFF_THRESHOLD:      model_cfg.off_threshold      = value;
      REG_MIN_SILENCE_FRAMES: model_cfg.min_silence_frames = value;
      REG_MIN_SPEECH_FRAMES:  model_cfg.min_speech_frames  = value;
      default: ;
    endcase
  endtask

  task automatic apply_config(input cfg_t setting);
    write_reg(REG_ON_THRESHOLD, setting.on_threshold);
    write_reg(REG_OFF_THRESHOLD, setting.off_threshold);
    write_reg(REG_MIN_SILENCE_FRAMES, setting.min_silence_frames);
    write_reg(REG_MIN_SPEECH_FRAMES, setting.min_speech_frames);
    cfg_valid <= 1'b0;
  endtask

  // Waits for every predicted segment, then lets any frame still in flight finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_segments.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_default_settings();
    send_frame(mk_frame('0, 1'b1, 1'b0));
    send_frame(mk_frame(ON_THRESHOLD_RST, 1'b0, 1'b0));
    send_frame(mk_frame(PROB_MAX, 1'b0, 1'b0));
    // Exactly on the lower threshold does not count as silence.
    send_frame(mk_frame(OFF_THRESHOLD_RST, 1'b0, 1'b0));
    send_frame(mk_frame(OFF_THRESHOLD_RST - 1'b1, 1'b0, 1'b0));
    // Speech cancels the pending silence.
    send_frame(mk_frame(PROB_MAX, 1'b0, 1'b0));
    repeat (9) send_frame(mk_frame('0, 1'b0, 1'b0));
    send_frame(mk_frame(PROB_MAX, 1'b0, 1'b0));
    send_frame(mk_frame('0, 1'b0, 1'b1));
    settle();
  endtask

  task automatic test_extreme_settings();
    write_reg(REG_UNUSED, PROB_MAX);
    apply_config('{on_threshold: PROB_MAX, off_threshold: PROB_MAX,
                   min_silence_frames: '0, min_speech_frames: '0});
    send_frame(mk_frame(PROB_MAX, 1'b1, 1'b1));
    // Speech is still active in the new call, so silence at index 0 closes a
    // segment of zero length, which is not reported.
    send_frame(mk_frame('0, 1'b1, 1'b0));
    send_frame(mk_frame(PROB_MAX, 1'b0, 1'b0));
    send_frame(mk_frame(PROB_MAX - 1'b1, 1'b0, 1'b0));
    settle();
  endtask

  // Calls of alternating speech and silence runs, with some noise on probabilities and call flags.
  task automatic send_random_calls(input int n_items);
    frame_t f;
    int     call_len;
    int     run_left;
    int     sent;
    bit     talking;
    sent     = 0;
    run_left = 0;
    talking  = 1'b0;
    while (sent < n_items) begin
      call_len = $urandom_range(3, 40);
      for (int k = 0; k < call_len; k++) begin
        if (run_left == 0) begin
          talking  = !talking;
          run_left = $urandom_range(1, 14);
        end
        run_left--;
        if (talking)
          f.frame_prob = FIELD_BITS'($urandom_range(model_cfg.on_threshold, PROB_MAX));
        else if ($urandom_range(0, 3) == 0)
          f.frame_prob = FIELD_BITS'($urandom_range(model_cfg.off_threshold,
                                                    model_cfg.on_threshold));
        else if (model_cfg.off_threshold == '0)
          f.frame_prob = '0;
        else
          f.frame_prob = FIELD_BITS'($urandom_range(0, model_cfg.off_threshold - 1));
        if ($urandom_range(0, 9) == 0) f.frame_prob = FIELD_BITS'($urandom);
        f.first_of_call = (k == 0) ^ ($urandom_range(0, 19) == 0);
        f.last_of_call  = (k == call_len - 1) ^ ($urandom_range(0, 19) == 0);
        send_frame(f);
        sent++;
      end
    end
  endtask

  task automatic test_random_calls();
    cfg_t setting;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        1: setting = '{on_threshold: PROB_MAX, off_threshold: 16'd1,
                       min_silence_frames: '0, min_speech_frames: PROB_MAX};
        2: setting = '{on_threshold: '0, off_threshold: PROB_MAX,
                       min_silence_frames: 16'd1, min_speech_frames: '0};
        default: begin
          setting.on_threshold       = FIELD_BITS'($urandom_range(28000, 60000));
          setting.off_threshold      = FIELD_BITS'($urandom_range(4000,
                                                                  setting.on_threshold));
          setting.min_silence_frames = (phase == 3) ? PROB_MAX :
                                       FIELD_BITS'($urandom_range(0, 6));
          setting.min_speech_frames  = FIELD_BITS'($urandom_range(0, 6));
        end
      endcase
      idle_on = (phase != 2) && (phase != 4);
      apply_config(setting);
      send_random_calls(PHASE_FRAMES);
      settle();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    segment_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_segments.size() == 0) begin
        $display("%0t: unexpected segment, expected none, actual %h", $time, out_data);
        err_count++;
      end else begin
        want = expected_segments.pop_front();
        if (out_data.seg_start !== want.seg_start) begin
          $display("%0t: seg_start mismatch, expected %0d, actual %0d",
                   $time, want.seg_start, out_data.seg_start);
          err_count++;
        end
        if (out_data.seg_end !== want.seg_end) begin
          $display("%0t: seg_end mismatch, expected %0d, actual %0d",
                   $time, want.seg_end, out_data.seg_end);
          err_count++;
        end
        if (out_data.ran_to_end !== want.ran_to_end) begin
          $display("%0t: ran_to_end mismatch, expected %0b, actual %0b",
                   $time, want.ran_to_end, out_data.ran_to_end);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d segments outstanding", $time,
               expected_segments.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    model_cfg = '{on_threshold: ON_THRESHOLD_RST, off_threshold: OFF_THRESHOLD_RST,
                  min_silence_frames: MIN_SILENCE_FRAMES_RST,
                  min_speech_frames: MIN_SPEECH_FRAMES_RST};
    track     = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_default_settings();
    test_extreme_settings();
    test_random_calls();
    if (expected_segments.size() != 0) err_count++;
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/vss_pkg.sv
sv/vss_cfg.sv
sv/vss_decide.sv
sv/vad_speech_segmenter.sv
sv/vss_checker.sv
tb/testbench.sv
